@@ design/gzrc_pkg.sv @@
// Shared types and constants for the gyro zero-rate calibration block.
`timescale 1ns / 1ps
`default_nettype none
package gzrc_pkg;

  // Axis count and sample width are fixed by the sensor word format
  localparam int NUM_AXES = 3;
  localparam int RATE_W   = 16;

  typedef logic signed [RATE_W-1:0] rate_t;
  typedef rate_t                    rate_vec_t [NUM_AXES];

endpackage : gzrc_pkg
`default_nettype wire

@@ design/gyro_zero_rate_calibrate_deadband_core.sv @@
// Gyro zero-rate calibration and deadband: top level.
// An accepted word's result is registered in the output register in the cycle after accept.
// Throughput: one word per cycle; the single output register is the only
//   stage, and the input is taken whenever that register is empty or drains.
// Reset (rst_n, synchronous, active low): clears sums, maxima, offsets, the
//   calibration counter and done flag; the next 2^CAL_SAMPLES_LOG2 words calibrate.
`timescale 1ns / 1ps
`default_nettype none
module gyro_zero_rate_calibrate_deadband_core
  import gzrc_pkg::*;
#(
  parameter int CAL_SAMPLES_LOG2 = 7
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_rate_x,
  input  wire logic signed [15:0] in_rate_y,
  input  wire logic signed [15:0] in_rate_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic signed [15:0]      out_z,
  output logic                    out_calibrating
);

  localparam int SUM_W = RATE_W + CAL_SAMPLES_LOG2;
  localparam int MAG_W = RATE_W + 1;

  typedef logic signed [SUM_W-1:0] sum_t;

  // Calibration state
  sum_t                        sum_r    [NUM_AXES];
  sum_t                        sum_nxt  [NUM_AXES];
  rate_t                       max_r    [NUM_AXES];
  rate_t                       max_nxt  [NUM_AXES];
  rate_t                       ofs_r    [NUM_AXES];
  rate_t                       ofs_nxt  [NUM_AXES];
  logic [CAL_SAMPLES_LOG2-1:0] cnt_r, cnt_nxt;
  logic                        done_r, done_nxt;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  rate_vec_t res_r, res_nxt;
  logic      cal_r, cal_nxt;

  rate_vec_t  rate_in;
  logic       in_acc;
  logic       last_cal;
  rate_t      diff    [NUM_AXES];
  logic [MAG_W-1:0] mag [NUM_AXES];

  assign rate_in[0] = in_rate_x;
  assign rate_in[1] = in_rate_y;
  assign rate_in[2] = in_rate_z;

  // Take a word when the output register is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign last_cal = (cnt_r == {CAL_SAMPLES_LOG2{1'b1}});

  // Per-axis calibration update and offset/deadband correction
  always_comb begin
    sum_nxt       = sum_r;
    max_nxt       = max_r;
    ofs_nxt       = ofs_r;
    cnt_nxt       = cnt_r;
    done_nxt      = done_r;
    res_nxt       = res_r;
    cal_nxt       = cal_r;
    out_valid_nxt = out_valid_r && !out_ready;
    for (int a = 0; a < NUM_AXES; a++) begin
      diff[a] = rate_t'(rate_in[a] - ofs_r[a]);
      mag[a]  = diff[a][RATE_W-1] ? MAG_W'(-{diff[a][RATE_W-1], diff[a]})
                                  : MAG_W'({1'b0, diff[a]});
    end
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      cal_nxt       = !done_r;
      if (!done_r) begin
        cnt_nxt = cnt_r + 1'b1;
        for (int a = 0; a < NUM_AXES; a++) begin
          sum_nxt[a] = sum_r[a] + SUM_W'(rate_in[a]);
          if (rate_in[a] > max_r[a]) begin
            max_nxt[a] = rate_in[a];
          end
          res_nxt[a] = '0;
          // Floor of the mean on the final calibration word
          if (last_cal) begin
            ofs_nxt[a] = rate_t'(sum_nxt[a] >>> CAL_SAMPLES_LOG2);
          end
        end
        if (last_cal) begin
          done_nxt = 1'b1;
        end
      end else begin
        for (int a = 0; a < NUM_AXES; a++) begin
          // Thresholds are never negative, so zero-extension is safe
          res_nxt[a] = (mag[a] < MAG_W'({1'b0, max_r[a]})) ? '0 : diff[a];
        end
      end
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        sum_r[a] <= '0;
        max_r[a] <= '0;
        ofs_r[a] <= '0;
      end
      cnt_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      max_r       <= max_nxt;
      ofs_r       <= ofs_nxt;
      cnt_r       <= cnt_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    cal_r <= cal_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_x           = res_r[0];
  assign out_y           = res_r[1];
  assign out_z           = res_r[2];
  assign out_calibrating = cal_r;

endmodule : gyro_zero_rate_calibrate_deadband_core
`default_nettype wire

@@ design/gzrc_chk.sv @@
// Port-level checker for the gyro calibration core, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module gzrc_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] out_x,
  input wire logic signed [15:0] out_y,
  input wire logic signed [15:0] out_z,
  input wire logic               out_calibrating
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(out_calibrating))
    else $error("stalled result word changed");

  // Calibration words carry zero rates
  a_cal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_calibrating |-> out_x == 16'sd0 && out_y == 16'sd0
      && out_z == 16'sd0)
    else $error("calibration word with nonzero rate");

  // Empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Once corrected words appear, calibration does not resume before reset
  a_cal_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_calibrating |=> !(out_valid && out_calibrating))
    else $error("calibration word after corrected word");

  // An accepted word yields a result word on the next cycle
  a_acc_res: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

endmodule : gzrc_chk

bind gyro_zero_rate_calibrate_deadband_core gzrc_chk u_gzrc_chk (.*);
`default_nettype wire
